FILE: sv/tpm_pkg.sv
// shared types and constants for the i2c target pointer memory
// no dependencies; used by every module of the block except tpm_ram

package tpm_pkg;

  localparam int STORE_DEPTH_DEF = 256;
  localparam int SIZE_W          = 9;
  localparam int BYTE_W          = 8;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd100;

  typedef enum logic [2:0] {
    OP_WRITE_BYTE = 3'd0,
    OP_READ_REQ   = 3'd1,
    OP_READ_DONE  = 3'd2,
    OP_STOP       = 3'd3,
    OP_WRITE_REQ  = 3'd4,
    OP_HOST_WR    = 3'd5,
    OP_HOST_RD    = 3'd6,
    OP_IGNORE     = 3'd7
  } opcode_t;

  typedef struct packed {
    opcode_t           opcode;
    logic [BYTE_W-1:0] data_in;
    logic [BYTE_W-1:0] host_offset;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic              error;
  } out_item_t;

  // store access issued by the control stage
  typedef struct packed {
    logic              wr_en;
    logic [BYTE_W-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              rd_en;
    logic [BYTE_W-1:0] rd_addr;
  } store_req_t;

  // what the result stage needs to know about an accepted item
  typedef struct packed {
    logic rd_hit;
    logic err;
  } stage_info_t;

endpackage

FILE: sv/tpm_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies

module tpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/tpm_store.sv
// byte store: ram plus one valid bit per entry so that reset clears it at once
// depends on tpm_pkg and tpm_ram

module tpm_store #(
  parameter int STORE_DEPTH = tpm_pkg::STORE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tpm_pkg::store_req_t         req,
  output logic [tpm_pkg::BYTE_W-1:0]  rd_data
);

  localparam int AW = $clog2(STORE_DEPTH);

  logic [STORE_DEPTH-1:0]       valid_r;
  logic                         vbit_r;
  logic [tpm_pkg::BYTE_W-1:0]   ram_q;

  tpm_ram #(
    .WIDTH (tpm_pkg::BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (req.wr_en),
    .wr_addr (req.wr_addr[AW-1:0]),
    .wr_data (req.wr_data),
    .rd_en   (req.rd_en),
    .rd_addr (req.rd_addr[AW-1:0]),
    .rd_data (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      vbit_r  <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid_r[req.wr_addr[AW-1:0]] <= 1'b1;
      end
      if (req.rd_en) begin
        vbit_r <= valid_r[req.rd_addr[AW-1:0]];
      end
    end
  end

  // an entry never written since reset reads as zero
  assign rd_data = vbit_r ? ram_q : '0;

endmodule

FILE: sv/tpm_ctrl.sv
// event decode, pointer state and range checks for one accepted item
// depends on tpm_pkg

module tpm_ctrl #(
  parameter int STORE_DEPTH = tpm_pkg::STORE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  tpm_pkg::in_item_t           item,
  input  logic [tpm_pkg::SIZE_W-1:0]  active_size,
  output tpm_pkg::store_req_t         req,
  output tpm_pkg::stage_info_t        info
);

  localparam logic [tpm_pkg::SIZE_W-1:0] DEPTH_LIM = tpm_pkg::SIZE_W'(STORE_DEPTH);

  logic [tpm_pkg::BYTE_W-1:0] ptr_r, ptr_nxt;
  logic                       pending_r, pending_nxt;
  logic [tpm_pkg::BYTE_W-1:0] ptr_inc;
  logic [tpm_pkg::SIZE_W-1:0] lim;
  logic                       ptr_ok, inc_ok, data_ok, offs_ok;

  assign lim     = (active_size > DEPTH_LIM) ? DEPTH_LIM : active_size;
  assign ptr_inc = ptr_r + 1'b1;
  assign ptr_ok  = {1'b0, ptr_r} < lim;
  assign inc_ok  = {1'b0, ptr_inc} < lim;
  assign data_ok = {1'b0, item.data_in} < lim;
  assign offs_ok = {1'b0, item.host_offset} < lim;

  always_comb begin
    ptr_nxt     = ptr_r;
    pending_nxt = pending_r;
    req         = '0;
    info        = '0;
    req.wr_data = item.data_in;
    req.wr_addr = ptr_r;
    req.rd_addr = ptr_r;
    case (item.opcode)
      tpm_pkg::OP_WRITE_BYTE: begin
        if (pending_r) begin
          // first byte after start or stop sets the pointer
          if (data_ok) begin
            ptr_nxt     = item.data_in;
            pending_nxt = 1'b0;
          end else begin
            info.err = 1'b1;
          end
        end else if (ptr_ok) begin
          req.wr_en = 1'b1;
          ptr_nxt   = ptr_inc;
        end else begin
          info.err = 1'b1;
        end
      end
      tpm_pkg::OP_READ_REQ: begin
        req.rd_en   = ptr_ok;
        info.rd_hit = ptr_ok;
        info.err    = !ptr_ok;
      end
      tpm_pkg::OP_READ_DONE: begin
        // pointer advances even when the read then falls out of range
        ptr_nxt     = ptr_inc;
        req.rd_addr = ptr_inc;
        req.rd_en   = inc_ok;
        info.rd_hit = inc_ok;
        info.err    = !inc_ok;
      end
      tpm_pkg::OP_STOP,
      tpm_pkg::OP_WRITE_REQ: begin
        pending_nxt = 1'b1;
      end
      tpm_pkg::OP_HOST_WR: begin
        req.wr_addr = item.host_offset;
        req.wr_en   = offs_ok;
        info.err    = !offs_ok;
      end
      tpm_pkg::OP_HOST_RD: begin
        req.rd_addr = item.host_offset;
        req.rd_en   = offs_ok;
        info.rd_hit = offs_ok;
        info.err    = !offs_ok;
      end
      default: begin
      end
    endcase
    req.wr_en = req.wr_en && accept;
    req.rd_en = req.rd_en && accept;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r     <= '0;
      pending_r <= 1'b1;
    end else if (accept) begin
      ptr_r     <= ptr_nxt;
      pending_r <= pending_nxt;
    end
  end

endmodule

FILE: sv/i2c_target_pointer_memory.sv
// top level of the i2c target pointer memory: handshakes, size register, result stage
// depends on tpm_pkg, tpm_ctrl and tpm_store

// Takes one bus or host event per clock while in_stall is low and gives exactly
// one result per event. The edge that takes an event updates the pointer and
// issues the store read; the registered read data moves into the output register
// once no result is held there or out_stall is low. With out_stall low the block
// sustains one event per cycle; the store's single registered read port and
// the output register set that figure.
// The store reads as zero after reset through one valid bit per entry, so there is
// no clearing pass and events are taken from the first cycle after reset.
// cfg_ready is always high; write active_size only while no event is in flight.

module i2c_target_pointer_memory #(
  parameter int STORE_DEPTH = tpm_pkg::STORE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  tpm_pkg::in_item_t           in_item,
  output logic                        out_valid,
  input  logic                        out_stall,
  output tpm_pkg::out_item_t          out_item,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tpm_pkg::SIZE_W-1:0]  cfg_data
);

  logic [tpm_pkg::SIZE_W-1:0]  size_r;
  logic                        s1_valid_r;
  tpm_pkg::stage_info_t        s1_info_r;
  logic                        out_valid_r;
  tpm_pkg::out_item_t          out_item_r;
  logic                        s1_move;
  logic                        accept;
  tpm_pkg::store_req_t         req;
  tpm_pkg::stage_info_t        info;
  logic [tpm_pkg::BYTE_W-1:0]  rd_data;

  assign s1_move   = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !s1_move;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  tpm_ctrl #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .item        (in_item),
    .active_size (size_r),
    .req         (req),
    .info        (info)
  );

  tpm_store #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r      <= tpm_pkg::SIZE_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        size_r <= cfg_data;
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_valid_r && s1_move) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_info_r <= info;
    end
    if (s1_valid_r && s1_move) begin
      out_item_r.read_data <= s1_info_r.rd_hit ? rd_data : '0;
      out_item_r.error     <= s1_info_r.err;
    end
  end

endmodule

FILE: sv/tpm_checker.sv
// port-level checks for the i2c target pointer memory, bound to the top level
// depends on tpm_pkg and i2c_target_pointer_memory

module tpm_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input tpm_pkg::out_item_t          out_item,
  input logic                        cfg_valid,
  input logic                        cfg_ready
);

  // the input side only backs up when a result is held at the output
  a_stall_cause: assert property (@(posedge clk)
    (!out_valid || !out_stall) |-> !in_stall)
    else $error("input stalled while output can drain");

  // an error transfer never carries data
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.error) |-> (out_item.read_data == '0))
    else $error("error result with nonzero read data");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
    else $error("stalled result changed");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("size write refused");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind i2c_target_pointer_memory tpm_checker u_tpm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);
